/* hdl/jmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jmd_pkg
// Shared types, constants and helpers for the joystick median direction
// decoder.
// ---------------------------------------------------------------------------
package jmd_pkg;

  localparam int WINDOW_DEF = 5;
  localparam int SAMPLE_W   = 8;
  localparam int DIR_W      = 4;

  localparam logic [SAMPLE_W-1:0] RING_RESET     = 8'd128;
  localparam logic [SAMPLE_W-1:0] CENTER_RESET   = 8'd128;
  localparam logic [SAMPLE_W-1:0] DEADZONE_RESET = 8'd12;
  localparam logic [SAMPLE_W-1:0] BYTE_IDLE      = 8'hFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_CENTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE      = 1'b1;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP       = 4'd0;
  localparam logic [DIR_W-1:0] DIR_FWD        = 4'd1;
  localparam logic [DIR_W-1:0] DIR_BACK       = 4'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd4;
  localparam logic [DIR_W-1:0] DIR_FWD_LEFT   = 4'd5;
  localparam logic [DIR_W-1:0] DIR_FWD_RIGHT  = 4'd6;
  localparam logic [DIR_W-1:0] DIR_BACK_LEFT  = 4'd7;
  localparam logic [DIR_W-1:0] DIR_BACK_RIGHT = 4'd8;

  // Vertical sign codes.
  localparam logic [1:0] VERT_NONE = 2'd0;
  localparam logic [1:0] VERT_UP   = 2'd1;
  localparam logic [1:0] VERT_DOWN = 2'd2;

  // Active-low button codes.
  localparam logic [SAMPLE_W-1:0] BTN_UP_A   = 8'hFE;
  localparam logic [SAMPLE_W-1:0] BTN_UP_B   = 8'hFC;
  localparam logic [SAMPLE_W-1:0] BTN_UP_C   = 8'hE6;
  localparam logic [SAMPLE_W-1:0] BTN_DOWN_A = 8'hFB;
  localparam logic [SAMPLE_W-1:0] BTN_DOWN_B = 8'hF9;
  localparam logic [SAMPLE_W-1:0] BTN_DOWN_C = 8'hE3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] button_byte;
    logic [SAMPLE_W-1:0] second_byte;
    logic [SAMPLE_W-1:0] third_byte;
    logic [SAMPLE_W-1:0] x_sample;
  } in_word_t;

  typedef struct packed {
    logic [DIR_W-1:0]    direction;
    logic [SAMPLE_W-1:0] filtered_x;
  } out_word_t;

  // Packet flags carried from the input register to the decode stage.
  typedef struct packed {
    logic       dead;
    logic [1:0] vert;
  } pkt_flags_t;

  function automatic logic [1:0] vert_of(input logic [SAMPLE_W-1:0] b);
    logic [1:0] v;
    v = VERT_NONE;
    if (b == BTN_UP_A || b == BTN_UP_B || b == BTN_UP_C) begin
      v = VERT_UP;
    end else if (b == BTN_DOWN_A || b == BTN_DOWN_B || b == BTN_DOWN_C) begin
      v = VERT_DOWN;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/joystick_median_direction.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// joystick_median_direction
// Median-filtered analog X axis with deadzone, combined with the button
// byte into a nine-way direction code.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_word   (button, second, third, analog X)
//   out      out_valid/ out_stall out_word  (direction, filtered_x)
//   cfg      cfg_we               cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low. The accept edge
// writes the sample ring and the input register; the result register is
// loaded from the input register when the output side can advance.
// Reset loads every ring entry with mid-scale, clears the write slot and
// fill count, and loads the register defaults. A held result with a full
// input register stalls the input side in the same cycle.
// ---------------------------------------------------------------------------
module joystick_median_direction
  import jmd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [SAMPLE_W-1:0]             center;
  logic [SAMPLE_W-1:0]             deadzone;
  logic                            s1_valid;
  pkt_flags_t                      s1_flags;
  logic                            s1_advance;
  logic                            in_take;
  logic [WINDOW-1:0][SAMPLE_W-1:0] samples;
  logic [CNT_W-1:0]                fill;
  logic [SAMPLE_W-1:0]             median;
  logic [DIR_W-1:0]                direction;

  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      center   <= CENTER_RESET;
      deadzone <= DEADZONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANALOG_CENTER: center   <= cfg_data;
        REG_DEADZONE:      deadzone <= cfg_data;
        default:           ;
      endcase
    end
  end

  jmd_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .push    (in_take),
    .sample  (in_word.x_sample),
    .samples (samples),
    .fill    (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_flags.dead <= in_word.button_byte == BYTE_IDLE &&
                       in_word.second_byte == BYTE_IDLE &&
                       in_word.third_byte  == BYTE_IDLE;
      s1_flags.vert <= vert_of(in_word.button_byte);
    end
  end

  jmd_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .samples (samples),
    .fill    (fill),
    .median  (median)
  );

  jmd_decode u_decode (
    .median    (median),
    .center    (center),
    .deadzone  (deadzone),
    .flags     (s1_flags),
    .direction (direction)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_word.direction  <= direction;
      out_word.filtered_x <= median;
    end
  end

`ifndef SYNTHESIS
  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted word did not reach the input register");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW))
    else $error("fill count above window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input register would be overwritten while held");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.direction <= DIR_BACK_RIGHT)
    else $error("direction code out of range");
`endif

endmodule
`default_nettype wire

/* hdl/jmd_ring.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jmd_ring
// Ring of the most recent analog X samples with a saturating fill count.
// ---------------------------------------------------------------------------
module jmd_ring
  import jmd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int CNT_W  = $clog2(WINDOW + 1),
  parameter int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  input  wire logic [SAMPLE_W-1:0]              sample,
  output logic      [WINDOW-1:0][SAMPLE_W-1:0]  samples,
  output logic      [CNT_W-1:0]                 fill
);

  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        samples[i] <= RING_RESET;
      end
    end else if (push) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (slot == SLOT_W'(i)) begin
          samples[i] <= sample;
        end
      end
      slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (fill != CNT_W'(WINDOW)) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/jmd_median.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jmd_median
// Rank-select median of the stored samples: each sample counts how many
// stored samples sort ahead of it, and the one at rank fill/2 is chosen.
// ---------------------------------------------------------------------------
module jmd_median
  import jmd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int CNT_W  = $clog2(WINDOW + 1)
) (
  input  wire logic [WINDOW-1:0][SAMPLE_W-1:0] samples,
  input  wire logic [CNT_W-1:0]                fill,
  output logic      [SAMPLE_W-1:0]             median
);

  logic [WINDOW-1:0]            used;
  logic [WINDOW-1:0][CNT_W-1:0] rank;
  logic [CNT_W-1:0]             target;

  assign target = fill >> 1;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      used[i] = CNT_W'(i) < fill;
    end
    // Equal values are ordered by slot so that every rank is unique.
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (used[j] && (samples[j] < samples[i] ||
                        (samples[j] == samples[i] && j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (used[i] && rank[i] == target) begin
        median = median | samples[i];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/jmd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jmd_decode
// Turns the median and the packet flags into one of nine direction codes.
// ---------------------------------------------------------------------------
module jmd_decode
  import jmd_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] median,
  input  wire logic [SAMPLE_W-1:0] center,
  input  wire logic [SAMPLE_W-1:0] deadzone,
  input  wire pkt_flags_t          flags,
  output logic      [DIR_W-1:0]    direction
);

  logic                below;
  logic [SAMPLE_W-1:0] gap;
  logic                still;

  assign below = median < center;
  assign gap   = below ? center - median : median - center;
  assign still = gap <= deadzone;

  always_comb begin
    if (flags.dead) begin
      direction = DIR_STOP;
    end else begin
      case (flags.vert)
        VERT_UP: begin
          direction = still ? DIR_FWD : (below ? DIR_FWD_LEFT : DIR_FWD_RIGHT);
        end
        VERT_DOWN: begin
          direction = still ? DIR_BACK : (below ? DIR_BACK_LEFT : DIR_BACK_RIGHT);
        end
        default: begin
          direction = still ? DIR_STOP : (below ? DIR_LEFT : DIR_RIGHT);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_joystick_median_direction.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_joystick_median_direction
// Self-checking bench for the median-filtered joystick direction decoder.
// Every accepted packet runs through a local model of the sample window,
// the median, the deadzone compare and the button decode; each result word
// is compared against the oldest prediction. Both channels idle at random,
// the receiver holds off once for a long stretch, and the two registers are
// swept through their extremes between phases.
// ---------------------------------------------------------------------------
module tb_joystick_median_direction;
  import jmd_pkg::*;

  localparam int WIN          = WINDOW_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data = '0;

  // Model state.
  logic [SAMPLE_W-1:0] ring_m [WIN];
  int                  slot_m;
  int                  count_m;
  logic [SAMPLE_W-1:0] center_m;
  logic [SAMPLE_W-1:0] deadzone_m;

  out_word_t           pending_dirs [$];
  int                  fail_count = 0;
  int                  cycle_count = 0;

  // Stimulus controls.
  bit                  src_idle_en = 1'b0;
  logic                sink_idle_en = 1'b0;
  logic                hold_req = 1'b0;
  int                  stall_left = 0;

  logic [SAMPLE_W-1:0] vert_codes [6] = '{BTN_UP_A, BTN_UP_B, BTN_UP_C,
                                          BTN_DOWN_A, BTN_DOWN_B, BTN_DOWN_C};

  joystick_median_direction i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      out_stall <= 1'b1;
      stall_left = HOLD_CYCLES - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Outputs are sampled mid-cycle, where they hold the value seen at the
  // next rising edge.
  always @(negedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dirs.size() == 0) begin
        $error("unexpected result word: direction=%0d filtered_x=%0d",
               out_word.direction, out_word.filtered_x);
        fail_count++;
      end else begin
        exp_w = pending_dirs.pop_front();
        if (out_word.direction !== exp_w.direction) begin
          $error("direction: expected %0d, actual %0d",
                 exp_w.direction, out_word.direction);
          fail_count++;
        end
        if (out_word.filtered_x !== exp_w.filtered_x) begin
          $error("filtered_x: expected %0d, actual %0d",
                 exp_w.filtered_x, out_word.filtered_x);
          fail_count++;
        end
      end
    end
  end

  // Push one sample into the window, take the median and decode the
  // direction, queuing the expected result word.
  task automatic compute_direction(input in_word_t w);
    logic [SAMPLE_W-1:0] sorted [WIN];
    logic [SAMPLE_W-1:0] key;
    logic [SAMPLE_W-1:0] med;
    logic [SAMPLE_W-1:0] gap;
    int                  n;
    int                  j;
    int                  xs;
    int                  ys;
    out_word_t           res;
    if (slot_m >= WIN) slot_m = 0;
    ring_m[slot_m] = w.x_sample;
    slot_m++;
    if (slot_m >= WIN) slot_m = 0;
    if (count_m < WIN) count_m++;
    n = count_m;
    for (int i = 0; i < n; i++) sorted[i] = ring_m[i];
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    med = sorted[n/2];
    res.filtered_x = med;
    if (w.button_byte == BYTE_IDLE && w.second_byte == BYTE_IDLE &&
        w.third_byte == BYTE_IDLE) begin
      res.direction = DIR_STOP;
    end else begin
      gap = (med >= center_m) ? med - center_m : center_m - med;
      if (gap <= deadzone_m) xs = 0;
      else if (med < center_m) xs = -1;
      else xs = 1;
      ys = 0;
      if (w.button_byte == BTN_UP_A || w.button_byte == BTN_UP_B ||
          w.button_byte == BTN_UP_C) begin
        ys = 1;
      end else if (w.button_byte == BTN_DOWN_A || w.button_byte == BTN_DOWN_B ||
                   w.button_byte == BTN_DOWN_C) begin
        ys = -1;
      end
      if (ys == 1) begin
        res.direction = (xs == 0) ? DIR_FWD : (xs < 0 ? DIR_FWD_LEFT : DIR_FWD_RIGHT);
      end else if (ys == -1) begin
        res.direction = (xs == 0) ? DIR_BACK : (xs < 0 ? DIR_BACK_LEFT : DIR_BACK_RIGHT);
      end else begin
        res.direction = (xs == 0) ? DIR_STOP : (xs < 0 ? DIR_LEFT : DIR_RIGHT);
      end
    end
    pending_dirs.push_back(res);
  endtask

  function automatic in_word_t packet(input logic [7:0] b1, input logic [7:0] b2,
                                      input logic [7:0] b3, input logic [7:0] ax);
    in_word_t w;
    w.button_byte = b1;
    w.second_byte = b2;
    w.third_byte  = b3;
    w.x_sample    = ax;
    return w;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken, or after a random idle gap when idling is on.
  task automatic send_packet(input in_word_t w);
    bit taken;
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    compute_direction(w);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Quiet the input side and wait until every result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_ANALOG_CENTER) center_m = val;
    else deadzone_m = val;
  endtask

  task automatic set_config(input logic [7:0] center, input logic [7:0] dz);
    wait_idle();
    write_reg(REG_ANALOG_CENTER, center);
    write_reg(REG_DEADZONE, dz);
  endtask

  function automatic logic [7:0] near_byte(input logic [7:0] target, input int spread);
    int v;
    v = int'(target) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic in_word_t random_packet(input logic [7:0] target);
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) w.button_byte = vert_codes[$urandom_range(0, 5)];
    else if (pick == 6) w.button_byte = BYTE_IDLE;
    else w.button_byte = 8'($urandom_range(0, 255));
    w.second_byte = ($urandom_range(0, 3) == 0) ? BYTE_IDLE : 8'($urandom_range(0, 255));
    w.third_byte  = ($urandom_range(0, 3) == 0) ? BYTE_IDLE : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 11) == 0) begin
      w.button_byte = BYTE_IDLE;
      w.second_byte = BYTE_IDLE;
      w.third_byte  = BYTE_IDLE;
    end
    // Mostly runs of samples near a target so the median settles there;
    // the rest are single outliers the filter should reject.
    if ($urandom_range(0, 7) == 0) w.x_sample = 8'($urandom_range(0, 255));
    else w.x_sample = near_byte(target, 6);
    return w;
  endfunction

  task automatic test_defaults_directed();
    // Window fills from empty: even and odd counts pick different medians.
    send_packet(packet(BTN_UP_A,   8'h00, 8'h00, 8'd0));
    send_packet(packet(BTN_UP_B,   8'h00, 8'h00, 8'd255));
    send_packet(packet(BTN_UP_C,   8'h00, 8'h00, 8'd128));
    // Median lands exactly on the deadzone edge, then one past it.
    send_packet(packet(BTN_DOWN_A, 8'h00, 8'h00, 8'd140));
    send_packet(packet(BTN_DOWN_B, 8'h00, 8'h00, 8'd141));
    send_packet(packet(BTN_DOWN_C, 8'h00, 8'h00, 8'd141));
    // A dead packet still stores its sample.
    send_packet(packet(BYTE_IDLE,  BYTE_IDLE, BYTE_IDLE, 8'd141));
    // Almost dead packets decode normally.
    send_packet(packet(BYTE_IDLE,  BYTE_IDLE, 8'hFE, 8'd0));
    send_packet(packet(BYTE_IDLE,  8'hFE, BYTE_IDLE, 8'd116));
    send_packet(packet(8'hFE,      BYTE_IDLE, BYTE_IDLE, 8'd116));
    send_packet(packet(8'h00,      8'h00, 8'h00, 8'd116));
    send_packet(packet(8'h00,      8'h00, 8'h00, 8'd115));
    send_packet(packet(BTN_UP_A,   8'hFF, 8'h00, 8'd115));
    send_packet(packet(BTN_DOWN_A, 8'h00, 8'hFF, 8'd0));
    send_packet(packet(8'h7F,      8'h80, 8'h01, 8'd0));
    send_packet(packet(BTN_UP_B,   8'hAA, 8'h55, 8'd0));
  endtask

  task automatic test_register_extremes();
    // Zero deadzone at the bottom: only a median of zero is centered.
    set_config(8'd0, 8'd0);
    send_packet(packet(BTN_UP_A,   8'h00, 8'h00, 8'd0));
    send_packet(packet(BTN_DOWN_B, 8'h00, 8'h00, 8'd1));
    send_packet(packet(8'h00,      8'h00, 8'h00, 8'd1));
    send_packet(packet(8'h00,      8'h00, 8'h00, 8'd1));
    // Full deadzone: horizontal motion is never seen.
    set_config(8'd255, 8'd255);
    send_packet(packet(BTN_UP_C,   8'h00, 8'h00, 8'd0));
    send_packet(packet(8'h12,      8'h00, 8'h00, 8'd0));
    send_packet(packet(BTN_DOWN_C, 8'h00, 8'h00, 8'd0));
    set_config(8'd255, 8'd0);
    send_packet(packet(8'h00,      8'h00, 8'h00, 8'd255));
    send_packet(packet(BTN_UP_A,   8'h00, 8'h00, 8'd255));
    send_packet(packet(BTN_DOWN_A, 8'h00, 8'h00, 8'd254));
  endtask

  task automatic test_output_hold_off();
    bit saved;
    saved = src_idle_en;
    set_config(8'd128, 8'd12);
    src_idle_en = 1'b0;
    hold_req <= 1'b1;
    for (int i = 0; i < 24; i++) send_packet(random_packet(8'($urandom_range(0, 255))));
    src_idle_en = saved;
  endtask

  task automatic test_random_traffic();
    logic [7:0] target;
    int         run;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(8'd128, 8'd12);
        1: set_config(8'd0, 8'd255);
        2: set_config(8'd255, 8'd0);
        3: set_config(8'd0, 8'd0);
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)));
      endcase
      if (phase == 7) begin
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
      end
      run = 0;
      target = center_m;
      for (int i = 0; i < 110; i++) begin
        if (run == 0) begin
          run = $urandom_range(3, 10);
          case ($urandom_range(0, 3))
            0: target = near_byte(center_m, int'(deadzone_m) + 3);
            1: target = 8'($urandom_range(0, 255));
            2: target = 8'd0;
            default: target = 8'd255;
          endcase
        end
        run--;
        send_packet(random_packet(target));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) ring_m[i] = RING_RESET;
    slot_m     = 0;
    count_m    = 0;
    center_m   = CENTER_RESET;
    deadzone_m = DEADZONE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
    test_defaults_directed();
    test_register_extremes();
    test_output_hold_off();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0 && pending_dirs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
